// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, status codes, controller states and the command/status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ORD_LT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_GT = 2'd2
    } t_order;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_COMBINE,
        S_GCD_SHIFT,
        S_GCD_ODD,
        S_GCD_LOOP,
        S_GCD_FIX,
        S_DIV,
        S_FINISH,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic prod;
        logic combine;
        logic gcd_shift;
        logic gcd_odd;
        logic gcd_step;
        logic gcd_fix;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic early;      // result settled without reduction
        logic both_even;
        logic u_even;
        logic v_zero;
        logic shift_zero;
        logic div_done;
    } t_stat;

endpackage

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Steps the datapath through products, binary GCD and quotient division.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rau_pkg::t_cmd  o_cmd,
    input  rau_pkg::t_stat i_stat
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_PROD;
            S_PROD:      n_state = S_COMBINE;
            S_COMBINE:   n_state = S_GCD_SHIFT;
            S_GCD_SHIFT: begin
                if (i_stat.early) n_state = S_OUT;
                else if (!i_stat.both_even) n_state = S_GCD_ODD;
            end
            S_GCD_ODD:   if (!i_stat.u_even) n_state = S_GCD_LOOP;
            S_GCD_LOOP:  if (i_stat.v_zero) n_state = S_GCD_FIX;
            S_GCD_FIX:   if (i_stat.shift_zero) n_state = S_DIV;
            S_DIV:       if (i_stat.div_done) n_state = S_FINISH;
            S_FINISH:    n_state = S_OUT;
            S_OUT:       if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PROD:      o_cmd.prod = 1'b1;
            S_COMBINE:   o_cmd.combine = 1'b1;
            S_GCD_SHIFT: o_cmd.gcd_shift = !i_stat.early;
            S_GCD_ODD:   o_cmd.gcd_odd = 1'b1;
            S_GCD_LOOP:  o_cmd.gcd_step = 1'b1;
            S_GCD_FIX: begin
                o_cmd.gcd_fix  = 1'b1;
                o_cmd.div_init = i_stat.shift_zero;
            end
            S_DIV:       o_cmd.div_step = 1'b1;
            S_FINISH:    o_cmd.finish = 1'b1;
            S_OUT:       o_out_valid = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/rau_dpath.sv =====
// ----------------------------------------------------------------------------
// rau_dpath: datapath of the rational arithmetic unit
// Sign-magnitude products, binary GCD and two restoring dividers in parallel.
// ----------------------------------------------------------------------------
module rau_dpath #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  rau_pkg::t_cmd          i_cmd,
    output rau_pkg::t_stat         o_stat,
    input  logic [2:0]             i_kind,
    input  logic signed [31:0]     i_a_num,
    input  logic signed [31:0]     i_a_den,
    input  logic signed [31:0]     i_b_num,
    input  logic signed [31:0]     i_b_den,
    output logic signed [31:0]     o_res_num,
    output logic [30:0]            o_res_den,
    output logic [1:0]             o_order,
    output logic [1:0]             o_status
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W + 1;           // sum of two products
    localparam int SW = $clog2(PW + 1);
    localparam int CW = $clog2(PW + 1);

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [2:0]    r_kind;
    logic [W-1:0]  r_nam, r_nbm, r_dam, r_dbm;
    logic          r_nan, r_nbn;
    logic [2*W-1:0] r_p0, r_p1, r_p2;        // product magnitudes
    logic          r_p0n, r_p1n;
    logic [PW-1:0] r_nm, r_dm, r_u, r_v, r_g;
    logic          r_nn;
    logic [SW-1:0] r_shift;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_r0, r_r1;
    logic          r_early;
    logic [1:0]    r_status, r_order;
    logic signed [31:0] r_res_num;
    logic [30:0]   r_res_den;

    logic [W-1:0] an, ad, bn, bd;
    assign an = i_a_num[W-1:0];
    assign ad = i_a_den[W-1:0];
    assign bn = i_b_num[W-1:0];
    assign bd = i_b_den[W-1:0];

    // combine products into numerator / denominator
    logic          sn0, sn1, n_nn, n_gt;
    logic [PW-1:0] m0, m1, n_nmag;
    always_comb begin
        m0  = {1'b0, r_p0};
        m1  = {1'b0, r_p1};
        sn0 = r_p0n && (r_p0 != '0);
        sn1 = r_p1n && (r_p1 != '0);
        n_gt = 1'b0;
        if (r_kind == OP_SUB) sn1 = !sn1 && (r_p1 != '0);
        if (sn0 == sn1) begin
            n_nmag = m0 + m1;
            n_nn   = sn0;
        end else if (m0 >= m1) begin
            n_nmag = m0 - m1;
            n_nn   = sn0;
        end else begin
            n_nmag = m1 - m0;
            n_nn   = sn1;
        end
        if (n_nmag == '0) n_nn = 1'b0;
        // compare: na*db versus nb*da
        if (sn0 != sn1)      n_gt = !sn0;
        else if (sn0)        n_gt = m0 < m1;
        else                 n_gt = m0 > m1;
    end

    // gcd step: v odd-shift, swap, subtract (one move per cycle)
    logic [PW-1:0] lo, hi;
    assign lo = (r_u > r_v) ? r_v : r_u;
    assign hi = (r_u > r_v) ? r_u : r_v;

    logic [PW:0] d0, d1;
    assign d0 = {r_r0[PW-1:0], r_nm[PW-1]} - {1'b0, r_g};
    assign d1 = {r_r1[PW-1:0], r_dm[PW-1]} - {1'b0, r_g};

    logic [PW-1:0] half, lim_n;
    assign half  = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    assign lim_n = r_nn ? half : half - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_nam  <= mag_of(an);
            r_nbm  <= mag_of(bn);
            r_dam  <= mag_of(ad);
            r_dbm  <= mag_of(bd);
            r_nan  <= (an != '0) && (an[W-1] != ad[W-1]);
            r_nbn  <= (bn != '0) && (bn[W-1] != bd[W-1]);
            r_res_num <= '0;
            r_res_den <= 31'd1;
            r_order   <= ORD_LT;
            r_status  <= ST_OK;
            r_early   <= 1'b0;
            if (i_kind > OP_CMP) begin
                r_early <= 1'b1;
            end else if (ad == '0 || bd == '0) begin
                r_early  <= 1'b1;
                r_status <= ST_ZERO_DEN;
            end else if (i_kind == OP_DIV && bn == '0) begin
                r_early  <= 1'b1;
                r_status <= ST_DIV_ZERO;
            end
        end
        if (i_cmd.prod) begin
            // p0 = first numerator term, p1 = second, p2 = denominator
            if (r_kind == OP_MUL) begin
                r_p0  <= r_nam * r_nbm;
                r_p0n <= r_nan != r_nbn;
                r_p1  <= '0;
                r_p2  <= r_dam * r_dbm;
            end else if (r_kind == OP_DIV) begin
                r_p0  <= r_nam * r_dbm;
                r_p0n <= r_nan != r_nbn;
                r_p1  <= '0;
                r_p2  <= r_dam * r_nbm;
            end else begin
                r_p0  <= r_nam * r_dbm;
                r_p0n <= r_nan;
                r_p1  <= r_nbm * r_dam;
                r_p2  <= r_dam * r_dbm;
            end
            r_p1n <= r_nbn;
        end
        if (i_cmd.combine) begin
            r_nm    <= n_nmag;
            r_nn    <= n_nn;
            r_dm    <= {1'b0, r_p2};
            r_u     <= n_nmag;
            r_v     <= {1'b0, r_p2};
            r_shift <= '0;
            if (r_kind == OP_CMP) begin
                r_early <= 1'b1;
                r_order <= (sn0 == sn1 && m0 == m1) ? ORD_EQ
                         : (n_gt ? ORD_GT : ORD_LT);
            end else if (n_nmag == '0) begin
                r_early <= 1'b1;
            end
        end
        if (i_cmd.gcd_shift && o_stat.both_even) begin
            r_u     <= r_u >> 1;
            r_v     <= r_v >> 1;
            r_shift <= r_shift + 1'b1;
        end
        if (i_cmd.gcd_odd && !r_u[0]) r_u <= r_u >> 1;
        if (i_cmd.gcd_step && r_v != '0) begin
            if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else begin
                r_u <= lo;
                r_v <= hi - lo;
            end
        end
        if (i_cmd.gcd_fix) begin
            if (r_shift != '0) begin
                r_u     <= r_u << 1;
                r_shift <= r_shift - 1'b1;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_u;
            r_r0  <= '0;
            r_r1  <= '0;
            r_cnt <= CW'(PW);
        end
        if (i_cmd.div_step) begin
            // one quotient bit of each division per cycle
            r_nm  <= {r_nm[PW-2:0], !d0[PW]};
            r_dm  <= {r_dm[PW-2:0], !d1[PW]};
            r_r0  <= d0[PW] ? {r_r0[PW-2:0], r_nm[PW-1]} : d0[PW-1:0];
            r_r1  <= d1[PW] ? {r_r1[PW-2:0], r_dm[PW-1]} : d1[PW-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.finish) begin
            if (r_nm > lim_n || r_dm >= half) begin
                r_status <= ST_OVERFLOW;
            end else begin
                r_res_num <= 32'(signed'(r_nn ? W'(-r_nm[W-1:0]) : r_nm[W-1:0]));
                r_res_den <= 31'(r_dm);
            end
        end
    end

    assign o_stat.early      = r_early;
    assign o_stat.both_even  = !r_u[0] && !r_v[0];
    assign o_stat.u_even     = !r_u[0];
    assign o_stat.v_zero     = r_v == '0;
    assign o_stat.shift_zero = r_shift == '0;
    assign o_stat.div_done   = r_cnt == CW'(1);

    assign o_res_num = (r_status != ST_OK) ? '0 : r_res_num;
    assign o_res_den = (r_status != ST_OK) ? 31'd1 : r_res_den;
    assign o_order   = (r_status != ST_OK) ? ORD_LT : r_order;
    assign o_status  = r_status;

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Sequence: for errors, compare, zero results and unused kinds the result is valid
// after the products and their combination, with no reduction; otherwise the
// binary GCD (common factors of two, then halving or subtract steps), the two
// divisions and a final range check follow before the result is valid.
// Throughput: one request at a time; the next is taken after the result leaves.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div/compare with reduction
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_order,
    output logic [1:0]         o_status
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    rau_dpath #(.WORD_BITS(WORD_BITS)) u_dpath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_kind    (i_kind),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_order   (o_order),
        .o_status  (o_status)
    );

endmodule

// ===== hdl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// Watches the handshakes and the shape of each result.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [30:0]        o_res_den,
    input logic signed [31:0] o_res_num,
    input logic [1:0]         o_order,
    input logic [1:0]         o_status
);
    import rau_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_res_den != '0) else $error("zero result denominator");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_res_num == '0 && o_res_den == 31'd1 && o_order == ORD_LT))
        else $error("error result not cleared");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_res_num)))
        else $error("result dropped while stalled");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_res_den   (o_res_den),
    .o_res_num   (o_res_num),
    .o_order     (o_order),
    .o_status    (o_status)
);
